// ----- rtl/stop_and_wait_sender_top_defines.svh -----
// Assertion macros for the stop-and-wait sender.
`ifndef STOP_AND_WAIT_SENDER_TOP_DEFINES_SVH
`define STOP_AND_WAIT_SENDER_TOP_DEFINES_SVH

// Same-cycle implication, checked out of reset.
`define SWS_ASSERT_NOW(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error(msg);

// Next-cycle implication, checked out of reset.
`define SWS_ASSERT_NEXT(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error(msg);

`endif

// ----- rtl/swsnd_pkg.sv -----
package swsnd_pkg;

  localparam int unsigned ByteW   = 8;
  localparam int unsigned TmoW    = 16;
  localparam int unsigned ElapsW  = 17;
  localparam int unsigned OpW     = 2;
  localparam int unsigned EventW  = 3;
  localparam int unsigned CfgIdxW = 3;
  localparam int unsigned CfgDatW = 16;

  // op codes
  localparam logic [OpW-1:0] OP_TICK = 2'd0;
  localparam logic [OpW-1:0] OP_SEND = 2'd1;
  localparam logic [OpW-1:0] OP_RX   = 2'd2;

  // result events
  localparam logic [EventW-1:0] EV_NONE   = 3'd0;
  localparam logic [EventW-1:0] EV_SENT   = 3'd1;
  localparam logic [EventW-1:0] EV_RESENT = 3'd2;
  localparam logic [EventW-1:0] EV_ACKED  = 3'd3;
  localparam logic [EventW-1:0] EV_GAVEUP = 3'd4;

  // register indexes
  localparam logic [CfgIdxW-1:0] REG_NODE_ADDR   = 3'd0;
  localparam logic [CfgIdxW-1:0] REG_DEST_ADDR   = 3'd1;
  localparam logic [CfgIdxW-1:0] REG_RELAY_CNT   = 3'd2;
  localparam logic [CfgIdxW-1:0] REG_RETRY_LIMIT = 3'd3;
  localparam logic [CfgIdxW-1:0] REG_ACK_TIMEOUT = 3'd4;

  localparam logic [ByteW-1:0]  ACK_TYPE        = 8'h02;
  localparam logic [ByteW-1:0]  SEQ_LAST        = 8'd254;  // modulo 255 wrap point
  localparam logic [ByteW-1:0]  RETRY_MAX       = 8'd255;
  localparam logic [ElapsW-1:0] ELAPSED_MAX     = 17'h1FFFF;
  localparam logic [ByteW-1:0]  RETRY_LIMIT_RST = 8'd3;
  localparam logic [TmoW-1:0]   ACK_TIMEOUT_RST = 16'd10000;

endpackage

// ----- rtl/stop_and_wait_sender_top.sv -----
// Stop-and-wait sender. Each input transaction is a millisecond tick, a send
// request or a received packet header; each yields exactly one result
// transaction in the cycle after acceptance, carried in an output register. The
// block accepts one transaction per clock cycle, as long as the output
// register is empty or being drained in the same cycle; the single output
// register sets that rate. A send advances the sequence number modulo 255 and
// emits a header; ticks while waiting count toward ack_timeout and, once the
// count passes it, the header is resent with the retry count bumped
// (saturating at 255). A packet ends the wait as acknowledged when it matches
// node address, type 2 and sequence, or as give-up when retries already
// exceed retry_limit. Configuration writes are taken at once and should be
// made while no transaction is in flight.
module stop_and_wait_sender_top (
  input  logic                                clk,
  input  logic                                rst_n,
  // configuration
  input  logic                                cfg_we,
  input  logic [swsnd_pkg::CfgIdxW-1:0]       cfg_index,
  input  logic [swsnd_pkg::CfgDatW-1:0]       cfg_wdata,
  // input channel
  input  logic                                in_valid,
  output logic                                in_ready,
  input  logic [swsnd_pkg::OpW-1:0]           in_op,
  input  logic [swsnd_pkg::ByteW-1:0]         in_rx_dest,
  input  logic [swsnd_pkg::ByteW-1:0]         in_rx_type,
  input  logic [swsnd_pkg::ByteW-1:0]         in_rx_seq,
  // result channel
  output logic                                out_valid,
  input  logic                                out_ready,
  output logic [swsnd_pkg::EventW-1:0]        out_event_res,
  output logic [swsnd_pkg::ByteW-1:0]         out_frame_source,
  output logic [swsnd_pkg::ByteW-1:0]         out_frame_dest,
  output logic [swsnd_pkg::ByteW-1:0]         out_frame_seq,
  output logic [swsnd_pkg::ByteW-1:0]         out_frame_relay,
  output logic [swsnd_pkg::ByteW-1:0]         out_retries_done
);

  // configuration registers
  logic [swsnd_pkg::ByteW-1:0]  node_addr_r;
  logic [swsnd_pkg::ByteW-1:0]  dest_addr_r;
  logic [swsnd_pkg::ByteW-1:0]  relay_cnt_r;
  logic [swsnd_pkg::ByteW-1:0]  retry_limit_r;
  logic [swsnd_pkg::TmoW-1:0]   ack_timeout_r;

  // protocol state
  logic [swsnd_pkg::ByteW-1:0]  seq_r,      seq_nxt;
  logic                         waiting_r,  waiting_nxt;
  logic [swsnd_pkg::ElapsW-1:0] elapsed_r,  elapsed_nxt;
  logic [swsnd_pkg::ByteW-1:0]  retry_r,    retry_nxt;

  // output register
  logic                         out_valid_r;
  logic [swsnd_pkg::EventW-1:0] ev_r,       ev_nxt;
  logic [swsnd_pkg::ByteW-1:0]  src_r,      src_nxt;
  logic [swsnd_pkg::ByteW-1:0]  dst_r,      dst_nxt;
  logic [swsnd_pkg::ByteW-1:0]  fseq_r,     fseq_nxt;
  logic [swsnd_pkg::ByteW-1:0]  relay_r,    relay_nxt;
  logic [swsnd_pkg::ByteW-1:0]  done_r,     done_nxt;

  logic in_fire;

  // Take a new transaction whenever the output slot frees up this cycle.
  assign in_ready = !out_valid_r || out_ready;
  assign in_fire  = in_valid && in_ready;

  always_comb begin
    logic [swsnd_pkg::ElapsW-1:0] elapsed_inc;
    logic [swsnd_pkg::ByteW-1:0]  retry_inc;
    logic                         ack_match;

    elapsed_inc = (elapsed_r == swsnd_pkg::ELAPSED_MAX) ? elapsed_r
                                                        : elapsed_r + 17'd1;
    retry_inc   = (retry_r == swsnd_pkg::RETRY_MAX) ? retry_r : retry_r + 8'd1;
    ack_match   = (in_rx_dest == node_addr_r) && (in_rx_type == swsnd_pkg::ACK_TYPE)
                  && (in_rx_seq == seq_r);

    seq_nxt     = seq_r;
    waiting_nxt = waiting_r;
    elapsed_nxt = elapsed_r;
    retry_nxt   = retry_r;

    ev_nxt      = swsnd_pkg::EV_NONE;
    src_nxt     = '0;
    dst_nxt     = '0;
    fseq_nxt    = '0;
    relay_nxt   = '0;
    done_nxt    = retry_r;

    unique case (in_op)
      swsnd_pkg::OP_SEND: begin
        // seq + 1 mod 255
        seq_nxt     = (seq_r >= swsnd_pkg::SEQ_LAST) ? seq_r - swsnd_pkg::SEQ_LAST
                                                     : seq_r + 8'd1;
        waiting_nxt = 1'b1;
        elapsed_nxt = '0;
        retry_nxt   = '0;
        ev_nxt      = swsnd_pkg::EV_SENT;
        src_nxt     = node_addr_r;
        dst_nxt     = dest_addr_r;
        fseq_nxt    = seq_nxt;
        relay_nxt   = relay_cnt_r;
        done_nxt    = '0;
      end
      swsnd_pkg::OP_TICK: begin
        if (waiting_r) begin
          elapsed_nxt = elapsed_inc;
          if (elapsed_inc > {1'b0, ack_timeout_r}) begin
            // timeout: resend same header
            elapsed_nxt = '0;
            retry_nxt   = retry_inc;
            ev_nxt      = swsnd_pkg::EV_RESENT;
            src_nxt     = node_addr_r;
            dst_nxt     = dest_addr_r;
            fseq_nxt    = seq_r;
            relay_nxt   = relay_cnt_r;
            done_nxt    = retry_inc;
          end
        end
      end
      swsnd_pkg::OP_RX: begin
        if (waiting_r) begin
          // limit check wins over a matching ack
          if (retry_r > retry_limit_r) begin
            waiting_nxt = 1'b0;
            elapsed_nxt = '0;
            retry_nxt   = '0;
            ev_nxt      = swsnd_pkg::EV_GAVEUP;
          end else if (ack_match) begin
            waiting_nxt = 1'b0;
            elapsed_nxt = '0;
            retry_nxt   = '0;
            ev_nxt      = swsnd_pkg::EV_ACKED;
          end
        end
      end
      default: begin
        // unused op: no state change, empty result
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      node_addr_r   <= '0;
      dest_addr_r   <= '0;
      relay_cnt_r   <= '0;
      retry_limit_r <= swsnd_pkg::RETRY_LIMIT_RST;
      ack_timeout_r <= swsnd_pkg::ACK_TIMEOUT_RST;
    end else if (cfg_we) begin
      unique case (cfg_index)
        swsnd_pkg::REG_NODE_ADDR:   node_addr_r   <= cfg_wdata[swsnd_pkg::ByteW-1:0];
        swsnd_pkg::REG_DEST_ADDR:   dest_addr_r   <= cfg_wdata[swsnd_pkg::ByteW-1:0];
        swsnd_pkg::REG_RELAY_CNT:   relay_cnt_r   <= cfg_wdata[swsnd_pkg::ByteW-1:0];
        swsnd_pkg::REG_RETRY_LIMIT: retry_limit_r <= cfg_wdata[swsnd_pkg::ByteW-1:0];
        swsnd_pkg::REG_ACK_TIMEOUT: ack_timeout_r <= cfg_wdata[swsnd_pkg::TmoW-1:0];
        default: begin
          // writes past the register list are dropped
        end
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      seq_r       <= '0;
      waiting_r   <= 1'b0;
      elapsed_r   <= '0;
      retry_r     <= '0;
      out_valid_r <= 1'b0;
    end else begin
      if (in_fire) begin
        seq_r     <= seq_nxt;
        waiting_r <= waiting_nxt;
        elapsed_r <= elapsed_nxt;
        retry_r   <= retry_nxt;
      end
      if (in_fire) begin
        out_valid_r <= 1'b1;
      end else if (out_ready) begin
        out_valid_r <= 1'b0;
      end
    end
  end

  // result payload, loaded with each accepted transaction
  always_ff @(posedge clk) begin
    if (in_fire) begin
      ev_r    <= ev_nxt;
      src_r   <= src_nxt;
      dst_r   <= dst_nxt;
      fseq_r  <= fseq_nxt;
      relay_r <= relay_nxt;
      done_r  <= done_nxt;
    end
  end

  assign out_valid        = out_valid_r;
  assign out_event_res    = ev_r;
  assign out_frame_source = src_r;
  assign out_frame_dest   = dst_r;
  assign out_frame_seq    = fseq_r;
  assign out_frame_relay  = relay_r;
  assign out_retries_done = done_r;

endmodule

// ----- rtl/swsnd_checker.sv -----
`include "stop_and_wait_sender_top_defines.svh"

module swsnd_checker (
  input logic                          clk,
  input logic                          rst_n,
  input logic                          in_valid,
  input logic                          in_ready,
  input logic [swsnd_pkg::OpW-1:0]     in_op,
  input logic                          out_valid,
  input logic                          out_ready,
  input logic [swsnd_pkg::EventW-1:0]  out_event_res,
  input logic [swsnd_pkg::ByteW-1:0]   out_frame_source,
  input logic [swsnd_pkg::ByteW-1:0]   out_frame_dest,
  input logic [swsnd_pkg::ByteW-1:0]   out_frame_seq,
  input logic [swsnd_pkg::ByteW-1:0]   out_frame_relay,
  input logic [swsnd_pkg::ByteW-1:0]   out_retries_done
);

  `SWS_ASSERT_NEXT(a_out_hold, out_valid && !out_ready, out_valid && $stable(out_event_res) && $stable(out_retries_done), "stalled result changed")

  `SWS_ASSERT_NEXT(a_send_result, in_valid && in_ready && in_op == swsnd_pkg::OP_SEND, out_valid && out_event_res == swsnd_pkg::EV_SENT && out_retries_done == '0, "send did not yield a fresh frame")

  `SWS_ASSERT_NOW(a_no_frame_zero, out_valid && out_event_res != swsnd_pkg::EV_SENT && out_event_res != swsnd_pkg::EV_RESENT, out_frame_source == '0 && out_frame_dest == '0 && out_frame_seq == '0 && out_frame_relay == '0, "header bytes set without a frame")

  `SWS_ASSERT_NOW(a_seq_range, out_valid && (out_event_res == swsnd_pkg::EV_SENT || out_event_res == swsnd_pkg::EV_RESENT), out_frame_seq != swsnd_pkg::RETRY_MAX, "sequence number outside modulo 255")

endmodule

bind stop_and_wait_sender_top swsnd_checker u_swsnd_checker (
  .clk              (clk),
  .rst_n            (rst_n),
  .in_valid         (in_valid),
  .in_ready         (in_ready),
  .in_op            (in_op),
  .out_valid        (out_valid),
  .out_ready        (out_ready),
  .out_event_res    (out_event_res),
  .out_frame_source (out_frame_source),
  .out_frame_dest   (out_frame_dest),
  .out_frame_seq    (out_frame_seq),
  .out_frame_relay  (out_frame_relay),
  .out_retries_done (out_retries_done)
);

// ----- tb/tb.sv -----
module tb;
  import swsnd_pkg::*;

  // op value 3 has no meaning; the sender must ignore it
  localparam logic [OpW-1:0] OP_UNUSED = 2'd3;
  localparam int WATCHDOG_LIMIT = 2000;
  localparam int PHASE_ITEMS = 120;
  localparam int NUM_PHASES = 7;

  // One input transaction: a tick, a send request or a received header
  typedef struct packed {
    logic [OpW-1:0]   op;
    logic [ByteW-1:0] dest;
    logic [ByteW-1:0] ptype;
    logic [ByteW-1:0] seq;
  } link_item_t;

  // One result transaction, in port order
  typedef struct packed {
    logic [EventW-1:0] ev;
    logic [ByteW-1:0]  src;
    logic [ByteW-1:0]  dst;
    logic [ByteW-1:0]  seq;
    logic [ByteW-1:0]  relay;
    logic [ByteW-1:0]  retries;
  } sender_result_t;

  logic                clk = 1'b0;
  logic                rst_n = 1'b0;
  logic                cfg_we = 1'b0;
  logic [CfgIdxW-1:0]  cfg_index = '0;
  logic [CfgDatW-1:0]  cfg_wdata = '0;
  logic                in_valid = 1'b0;
  logic                in_ready;
  logic [OpW-1:0]      in_op = '0;
  logic [ByteW-1:0]    in_rx_dest = '0;
  logic [ByteW-1:0]    in_rx_type = '0;
  logic [ByteW-1:0]    in_rx_seq = '0;
  logic                out_valid;
  logic                out_ready = 1'b0;
  logic [EventW-1:0]   out_event_res;
  logic [ByteW-1:0]    out_frame_source;
  logic [ByteW-1:0]    out_frame_dest;
  logic [ByteW-1:0]    out_frame_seq;
  logic [ByteW-1:0]    out_frame_relay;
  logic [ByteW-1:0]    out_retries_done;

  stop_and_wait_sender_top dut (
    .clk              (clk),
    .rst_n            (rst_n),
    .cfg_we           (cfg_we),
    .cfg_index        (cfg_index),
    .cfg_wdata        (cfg_wdata),
    .in_valid         (in_valid),
    .in_ready         (in_ready),
    .in_op            (in_op),
    .in_rx_dest       (in_rx_dest),
    .in_rx_type       (in_rx_type),
    .in_rx_seq        (in_rx_seq),
    .out_valid        (out_valid),
    .out_ready        (out_ready),
    .out_event_res    (out_event_res),
    .out_frame_source (out_frame_source),
    .out_frame_dest   (out_frame_dest),
    .out_frame_seq    (out_frame_seq),
    .out_frame_relay  (out_frame_relay),
    .out_retries_done (out_retries_done)
  );

  always begin
    #1 clk = 1'b1;
    #1 clk = 1'b0;
  end

  // Shadow copy of the registers, written alongside the port
  logic [ByteW-1:0] node_addr_q, dest_addr_q, relay_cnt_q, retry_limit_q;
  logic [TmoW-1:0]  ack_timeout_q;

  // Shadow copy of the sender's state
  logic [ByteW-1:0]  seq_q;
  logic              waiting_q;
  logic [ElapsW-1:0] elapsed_q;
  logic [ByteW-1:0]  retries_q;

  link_item_t     send_queue[$];      // items still to be presented
  sender_result_t predicted_results[$];

  int  items_queued = 0;
  int  items_accepted = 0;
  int  fail_count = 0;
  int  settings_count = 0;
  int  event_seen[8];
  int  gap_left = 0;
  int  stall_left = 0;
  int  idle_cycles = 0;
  bit  calm = 1'b0;                   // no idling on either side when set
  logic [ByteW-1:0] gen_seq = '0;     // sequence the sender will hold when the item lands

  function automatic sender_result_t frame_header(input logic [EventW-1:0] ev);
    sender_result_t r;
    r.ev      = ev;
    r.src     = node_addr_q;
    r.dst     = dest_addr_q;
    r.seq     = seq_q;
    r.relay   = relay_cnt_q;
    r.retries = retries_q;
    return r;
  endfunction

  // Steps the shadow state by one accepted transaction and returns its result
  function automatic sender_result_t advance_sender(input link_item_t it);
    sender_result_t r;
    r = '0;
    r.retries = retries_q;
    case (it.op)
      OP_SEND: begin
        // a new frame drops any wait on the old one
        seq_q     = (seq_q == SEQ_LAST) ? '0 : seq_q + 1'b1;
        waiting_q = 1'b1;
        elapsed_q = '0;
        retries_q = '0;
        r = frame_header(EV_SENT);
      end
      OP_TICK: begin
        if (waiting_q) begin
          if (elapsed_q != ELAPSED_MAX) elapsed_q = elapsed_q + 1'b1;
          if (elapsed_q > {1'b0, ack_timeout_q}) begin
            if (retries_q != RETRY_MAX) retries_q = retries_q + 1'b1;
            elapsed_q = '0;
            r = frame_header(EV_RESENT);
          end
        end
      end
      OP_RX: begin
        // give-up wins over a matching ack; short of give-up, a non-matching packet changes nothing
        if (waiting_q && (retries_q > retry_limit_q ||
            (it.dest == node_addr_q && it.ptype == ACK_TYPE && it.seq == seq_q))) begin
          r.ev = (retries_q > retry_limit_q) ? EV_GAVEUP : EV_ACKED;
          waiting_q = 1'b0;
          elapsed_q = '0;
          retries_q = '0;
        end
      end
      default: ;
    endcase
    return r;
  endfunction

  // Input driver: presents queued items, holds each until accepted,
  // and inserts random gaps between them.
  always @(posedge clk) begin : driver
    link_item_t nxt;
    logic       valid_nxt;
    valid_nxt = in_valid;
    if (rst_n) begin
      if (in_valid && in_ready) begin
        predicted_results.push_back(
          advance_sender('{in_op, in_rx_dest, in_rx_type, in_rx_seq}));
        items_accepted++;
        valid_nxt = 1'b0;
      end
      if (!valid_nxt) begin
        if (gap_left > 0) begin
          gap_left--;
        end else if (send_queue.size() > 0) begin
          nxt = send_queue.pop_front();
          in_op      <= nxt.op;
          in_rx_dest <= nxt.dest;
          in_rx_type <= nxt.ptype;
          in_rx_seq  <= nxt.seq;
          valid_nxt = 1'b1;
          if (!calm && $urandom_range(0, 7) == 0) gap_left = $urandom_range(1, 9);
        end
      end
    end
    in_valid <= valid_nxt;
  end

  // Result monitor: checks each result transaction against the oldest
  // prediction and applies random backpressure.
  always @(posedge clk) begin : monitor
    sender_result_t got, want;
    if (rst_n && out_valid && out_ready) begin
      got = {out_event_res, out_frame_source, out_frame_dest, out_frame_seq,
             out_frame_relay, out_retries_done};
      event_seen[got.ev]++;
      if (predicted_results.size() == 0) begin
        fail_count++;
        if (fail_count <= 10)
          $display("unexpected result: ev=%0d src=%0d dst=%0d seq=%0d relay=%0d retries=%0d",
                   got.ev, got.src, got.dst, got.seq, got.relay, got.retries);
      end else begin
        want = predicted_results.pop_front();
        if (got.ev !== want.ev || got.src !== want.src || got.dst !== want.dst ||
            got.seq !== want.seq || got.relay !== want.relay ||
            got.retries !== want.retries) begin
          fail_count++;
          if (fail_count <= 10) begin
            $display("mismatch: got  ev=%0d src=%0d dst=%0d seq=%0d relay=%0d retries=%0d",
                     got.ev, got.src, got.dst, got.seq, got.relay, got.retries);
            $display("          want ev=%0d src=%0d dst=%0d seq=%0d relay=%0d retries=%0d",
                     want.ev, want.src, want.dst, want.seq, want.relay, want.retries);
          end
        end
      end
    end
    if (stall_left > 0) begin
      stall_left--;
      out_ready <= 1'b0;
    end else if (!calm && $urandom_range(0, 11) == 0) begin
      stall_left = $urandom_range(0, 8);
      out_ready <= 1'b0;
    end else begin
      out_ready <= 1'b1;
    end
  end

  // Watchdog: ends the run if no transaction moves on either channel for too long
  always @(posedge clk) begin
    if ((in_valid && in_ready) || (out_valid && out_ready))
      idle_cycles <= 0;
    else
      idle_cycles <= idle_cycles + 1;
    if (idle_cycles >= WATCHDOG_LIMIT) begin
      $display("TB_ERROR");
      $finish;
    end
  end

  task automatic queue_item(input logic [OpW-1:0] op, input logic [ByteW-1:0] d,
                            input logic [ByteW-1:0] k, input logic [ByteW-1:0] s);
    send_queue.push_back('{op, d, k, s});
    items_queued++;
    if (op == OP_SEND) gen_seq = (gen_seq == SEQ_LAST) ? '0 : gen_seq + 1'b1;
  endtask

  // An acknowledgement that matches the frame outstanding at that point
  task automatic queue_ack();
    queue_item(OP_RX, node_addr_q, ACK_TYPE, gen_seq);
  endtask

  // Mostly well-formed traffic: ticks, sends and matching acks, with near
  // misses, junk packets and the unused op mixed in.
  task automatic queue_random(input int n);
    logic [ByteW-1:0] d, k, s;
    int r;
    repeat (n) begin
      r = $urandom_range(0, 99);
      d = 8'($urandom_range(0, 255));
      k = 8'($urandom_range(0, 255));
      s = 8'($urandom_range(0, 255));
      if (r < 38) begin
        queue_item(OP_TICK, d, k, s);
      end else if (r < 58) begin
        queue_item(OP_SEND, d, k, s);
      end else if (r < 63) begin
        queue_item(OP_UNUSED, d, k, s);
      end else begin
        r = $urandom_range(0, 9);
        if (r < 5) begin
          queue_ack();
        end else if (r < 8) begin
          // one header field off
          d = node_addr_q;
          k = ACK_TYPE;
          s = gen_seq;
          case ($urandom_range(0, 2))
            0:       d = d ^ 8'($urandom_range(1, 255));
            1:       k = k ^ 8'($urandom_range(1, 255));
            default: s = s ^ 8'($urandom_range(1, 255));
          endcase
          queue_item(OP_RX, d, k, s);
        end else begin
          queue_item(OP_RX, d, k, s);
        end
      end
    end
  endtask

  // Wait until every queued transaction is accepted and every result has arrived
  task automatic wait_drained();
    while (items_accepted != items_queued || predicted_results.size() != 0)
      @(posedge clk);
    repeat (3) @(posedge clk);
  endtask

  task automatic write_reg(input logic [CfgIdxW-1:0] idx, input logic [CfgDatW-1:0] val);
    @(posedge clk);
    cfg_we    <= 1'b1;
    cfg_index <= idx;
    cfg_wdata <= val;
    case (idx)
      REG_NODE_ADDR:   node_addr_q   = val[ByteW-1:0];
      REG_DEST_ADDR:   dest_addr_q   = val[ByteW-1:0];
      REG_RELAY_CNT:   relay_cnt_q   = val[ByteW-1:0];
      REG_RETRY_LIMIT: retry_limit_q = val[ByteW-1:0];
      REG_ACK_TIMEOUT: ack_timeout_q = val;
      default: ;
    endcase
  endtask

  // Only called with the link drained
  task automatic configure(input logic [ByteW-1:0] node, input logic [ByteW-1:0] dest,
                           input logic [ByteW-1:0] relay, input logic [ByteW-1:0] limit,
                           input logic [TmoW-1:0] tmo);
    write_reg(REG_NODE_ADDR, CfgDatW'(node));
    write_reg(REG_DEST_ADDR, CfgDatW'(dest));
    write_reg(REG_RELAY_CNT, CfgDatW'(relay));
    write_reg(REG_RETRY_LIMIT, CfgDatW'(limit));
    write_reg(REG_ACK_TIMEOUT, tmo);
    @(posedge clk);
    cfg_we <= 1'b0;
    settings_count++;
  endtask

  initial begin : stimulus
    int p;
    node_addr_q   = '0;
    dest_addr_q   = '0;
    relay_cnt_q   = '0;
    retry_limit_q = RETRY_LIMIT_RST;
    ack_timeout_q = ACK_TIMEOUT_RST;
    seq_q     = '0;
    waiting_q = 1'b0;
    elapsed_q = '0;
    retries_q = '0;
    foreach (event_seen[e]) event_seen[e] = 0;

    repeat (2) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    // Reset settings: idle traffic is ignored, then the basic ack paths
    queue_item(OP_TICK, 8'h00, 8'h00, 8'h00);
    queue_item(OP_RX, 8'h00, ACK_TYPE, 8'h00);       // would match, but nothing outstanding
    queue_item(OP_UNUSED, 8'hFF, 8'hFF, 8'hFF);
    queue_item(OP_SEND, 8'hFF, 8'hFF, 8'hFF);
    queue_item(OP_TICK, 8'hFF, 8'hFF, 8'hFF);
    queue_item(OP_RX, 8'hFF, ACK_TYPE, gen_seq);     // wrong destination
    queue_item(OP_RX, node_addr_q, 8'h03, gen_seq);  // wrong type
    queue_item(OP_RX, node_addr_q, ACK_TYPE, gen_seq ^ 8'h80);
    queue_item(OP_UNUSED, 8'h00, ACK_TYPE, gen_seq);
    queue_ack();
    queue_item(OP_SEND, 8'h00, 8'h00, 8'h00);
    queue_item(OP_SEND, 8'h00, 8'h00, 8'h00);        // send while waiting
    queue_ack();
    wait_drained();

    // Zero timeout and zero retry limit: every tick resends, any packet after a resend gives up
    configure(8'hFF, 8'hFF, 8'hFF, 8'h00, 16'd0);
    queue_item(OP_SEND, 8'h00, 8'h00, 8'h00);
    queue_item(OP_TICK, 8'h00, 8'h00, 8'h00);
    queue_item(OP_TICK, 8'h00, 8'h00, 8'h00);
    queue_item(OP_RX, 8'h12, 8'h34, 8'h56);
    queue_item(OP_SEND, 8'h00, 8'h00, 8'h00);
    queue_ack();                                     // no retries yet, so acked
    queue_item(OP_RX, 8'hFF, ACK_TYPE, gen_seq);     // nothing outstanding
    wait_drained();

    // Timeout of one: resend on every second tick; limit boundary
    configure(8'h00, 8'h00, 8'h00, 8'h01, 16'd1);
    queue_item(OP_SEND, 8'h00, 8'h00, 8'h00);
    repeat (4) queue_item(OP_TICK, 8'h00, 8'h00, 8'h00);
    queue_ack();                                     // two retries past a limit of one
    queue_item(OP_SEND, 8'h00, 8'h00, 8'h00);
    repeat (2) queue_item(OP_TICK, 8'h00, 8'h00, 8'h00);
    queue_ack();                                     // one retry, not past the limit
    wait_drained();

    // Retry count saturation, then enough sends to wrap the sequence number
    configure(8'h5A, 8'hA5, 8'h3C, 8'hFF, 16'd0);
    queue_item(OP_SEND, 8'h00, 8'h00, 8'h00);
    repeat (260) queue_item(OP_TICK, 8'($urandom_range(0, 255)), 8'h00, 8'h00);
    queue_ack();
    repeat (256) queue_item(OP_SEND, 8'($urandom_range(0, 255)),
                            8'($urandom_range(0, 255)), 8'($urandom_range(0, 255)));
    queue_ack();
    wait_drained();

    // Random phases, each under its own settings; the drain between phases
    // also holds the sender off until every result is back.
    for (p = 0; p < NUM_PHASES; p++) begin
      case (p)
        0: configure(8'h00, 8'hFF, 8'h00, 8'd2, 16'd3);
        1: configure(8'hFF, 8'h00, 8'hFF, 8'd0, 16'd0);
        2: configure(8'($urandom_range(0, 255)), 8'($urandom_range(0, 255)),
                     8'($urandom_range(0, 255)), 8'hFF, 16'd1);
        3: configure(8'($urandom_range(0, 255)), 8'($urandom_range(0, 255)),
                     8'($urandom_range(0, 255)), 8'($urandom_range(0, 6)), 16'hFFFF);
        default: configure(8'($urandom_range(0, 255)), 8'($urandom_range(0, 255)),
                           8'($urandom_range(0, 255)), 8'($urandom_range(0, 5)),
                           16'($urandom_range(1, 6)));
      endcase
      // last phase runs at full rate on both sides
      if (p == NUM_PHASES - 1) calm = 1'b1;
      queue_random(PHASE_ITEMS);
      wait_drained();
    end

    repeat (5) @(posedge clk);
    $display("Covered %0d transactions over %0d register settings",
             items_accepted, settings_count);
    $display("Results: %0d quiet, %0d sent, %0d resent, %0d acked, %0d gave up, %0d failures",
             event_seen[EV_NONE], event_seen[EV_SENT], event_seen[EV_RESENT],
             event_seen[EV_ACKED], event_seen[EV_GAVEUP], fail_count);
    if (fail_count == 0 && predicted_results.size() == 0)
      $display("TB_OK");
    else
      $display("TB_ERROR");
    $finish;
  end

endmodule
